// ===== hw/rtl/vagd_pkg.sv =====
// ============================================================================
// vagd_pkg: shared types and constants of the VAG ADPCM block decoder
// Holds the decode job word, the queue status group, the fixed history
// width and the predictor coefficient tables.
// ============================================================================
package vagd_pkg;

  // Nibbles in one 16-byte block and bits of packed nibble data.
  localparam int NIBBLES    = 28;
  localparam int DATA_W     = 4 * NIBBLES;
  localparam int HIST_W     = 40;
  localparam int QUEUE_DEPTH = 2;

  // Flag byte that ends the stream.
  localparam logic [7:0] END_FLAG = 8'd7;

  // Saturation limits of the history.
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // One decode job handed from the front to the back.
  typedef struct packed {
    logic              clear;
    logic              stereo;
    logic [7:0]        l_hdr;
    logic [DATA_W-1:0] l_data;
    logic [7:0]        r_hdr;
    logic [DATA_W-1:0] r_data;
  } vagd_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } vagd_q_status_t;

  // First predictor tap in 64ths; indexes above 4 use the last entry.
  function automatic logic signed [7:0] coef_one(input logic [3:0] pred);
    logic signed [7:0] c;
    case (pred)
      4'd0:    c = 8'sd0;
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      default: c = 8'sd122;
    endcase
    return c;
  endfunction

  // Second predictor tap in 64ths; indexes above 4 use the last entry.
  function automatic logic signed [7:0] coef_two(input logic [3:0] pred);
    logic signed [7:0] c;
    case (pred)
      4'd0:    c = 8'sd0;
      4'd1:    c = 8'sd0;
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      default: c = -8'sd60;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/vagd_queue.sv =====
// ============================================================================
// vagd_queue: short job queue between front and back
// A small circular buffer of decode jobs with full and empty status.
// ============================================================================
module vagd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  vagd_pkg::vagd_job_t     push_job,
  input  logic                    pop,
  output vagd_pkg::vagd_job_t     head_job,
  output vagd_pkg::vagd_q_status_t status
);
  import vagd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vagd_job_t          entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job     = entries_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ===== hw/rtl/vagd_front.sv =====
// ============================================================================
// vagd_front: block intake and classification
// Accepts input words, tracks restart, end of stream and left/right pairing,
// holds a left block and queues decode jobs for the back.
// ============================================================================
module vagd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_restart,
  input  logic [7:0]               in_block_header,
  input  logic [7:0]               in_block_flag,
  input  logic [63:0]              in_data_low,
  input  logic [47:0]              in_data_high,
  input  vagd_pkg::vagd_q_status_t q_status,
  output logic                     push,
  output vagd_pkg::vagd_job_t      push_job
);
  import vagd_pkg::*;

  logic              stereo_r;
  logic              waiting_r, waiting_nxt;
  logic              ended_r, ended_nxt;
  logic              clear_r, clear_nxt;
  logic [7:0]        held_hdr_r;
  logic [DATA_W-1:0] held_data_r;
  logic              hold_left;
  logic              accept;
  logic              eff_ended;
  logic              eff_waiting;
  logic              eff_clear;
  logic              is_end;
  logic [DATA_W-1:0] in_data;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign in_data  = {in_data_high, in_data_low};
  assign is_end   = (in_block_flag == END_FLAG);

  // A restart takes effect before the word itself is classified.
  assign eff_ended   = in_restart ? 1'b0 : ended_r;
  assign eff_waiting = in_restart ? 1'b0 : waiting_r;
  assign eff_clear   = in_restart || clear_r;

  // Classification of one accepted word.
  always_comb begin
    waiting_nxt = waiting_r;
    ended_nxt   = ended_r;
    clear_nxt   = clear_r;
    push        = 1'b0;
    hold_left   = 1'b0;
    push_job.clear  = eff_clear;
    push_job.stereo = stereo_r;
    push_job.l_hdr  = stereo_r ? held_hdr_r : in_block_header;
    push_job.l_data = stereo_r ? held_data_r : in_data;
    push_job.r_hdr  = in_block_header;
    push_job.r_data = in_data;
    if (accept) begin
      waiting_nxt = eff_waiting;
      ended_nxt   = eff_ended;
      clear_nxt   = eff_clear;
      if (!eff_ended) begin
        if (!stereo_r || eff_waiting) begin
          waiting_nxt = 1'b0;
          if (is_end) begin
            ended_nxt = 1'b1;
          end else begin
            push      = 1'b1;
            clear_nxt = 1'b0;
          end
        end else if (is_end) begin
          ended_nxt = 1'b1;
        end else begin
          hold_left   = 1'b1;
          waiting_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r  <= 1'b0;
      waiting_r <= 1'b0;
      ended_r   <= 1'b0;
      clear_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stereo_r <= cfg_wr_data;
      end
      waiting_r <= waiting_nxt;
      ended_r   <= ended_nxt;
      clear_r   <= clear_nxt;
    end
  end

  // Held left block, read only after it was written.
  always_ff @(posedge clk) begin
    if (hold_left) begin
      held_hdr_r  <= in_block_header;
      held_data_r <= in_data;
    end
  end

endmodule

// ===== hw/rtl/vagd_back.sv =====
// ============================================================================
// vagd_back: nibble decoder and sample output
// Takes jobs from the queue and decodes one nibble per cycle through the
// two-tap predictor unless stalled, interleaving left/right for stereo pairs.
// ============================================================================
module vagd_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vagd_pkg::vagd_job_t      head_job,
  input  vagd_pkg::vagd_q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_sample,
  output logic                     out_channel,
  output logic                     out_last_of_block
);
  import vagd_pkg::*;

  localparam int BASE_SHIFT = FRACTION_BITS + 6;
  localparam int SUM_W = (((16 + BASE_SHIFT) > (HIST_W + 8)) ?
                          (16 + BASE_SHIFT) : (HIST_W + 8)) + 2;
  localparam int IDX_W = $clog2(NIBBLES);
  localparam logic signed [HIST_W:0] ROUND_BIAS =
    (HIST_W+1)'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic signed [HIST_W:0] PCM_MAX = (HIST_W+1)'(32767);
  localparam logic signed [HIST_W:0] PCM_MIN = -(HIST_W+1)'(32768);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     stereo_r, stereo_nxt;
  logic                     ch_r, ch_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [7:0]               l_hdr_r, r_hdr_r;
  logic [DATA_W-1:0]        l_data_r, r_data_r;
  logic signed [HIST_W-1:0] lrec_r, lrec_nxt, lold_r, lold_nxt;
  logic signed [HIST_W-1:0] rrec_r, rrec_nxt, rold_r, rold_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [HIST_W-1:0] out_hist_r;
  logic                     out_ch_r, out_last_r;

  logic                     adv;
  logic                     last;
  logic [7:0]               hdr;
  logic [3:0]               nib;
  logic signed [15:0]       word_sh;
  logic signed [7:0]        c1, c2;
  logic signed [HIST_W-1:0] recent, older;
  logic signed [SUM_W-1:0]  base, p1, p2, sum, div;
  logic                     ovf;
  logic signed [HIST_W-1:0] next_hist;
  logic signed [HIST_W:0]   h_ext, adj, quo;

  assign pop  = (state_r == ST_IDLE) && !q_status.empty;
  assign adv  = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign last = (idx_r == IDX_W'(NIBBLES - 1)) && (!stereo_r || ch_r);

  // Predictor step for the current channel's nibble.
  always_comb begin
    hdr     = ch_r ? r_hdr_r : l_hdr_r;
    nib     = ch_r ? r_data_r[3:0] : l_data_r[3:0];
    recent  = ch_r ? rrec_r : lrec_r;
    older   = ch_r ? rold_r : lold_r;
    c1      = coef_one(hdr[7:4]);
    c2      = coef_two(hdr[7:4]);
    word_sh = $signed({nib, 12'h000}) >>> hdr[3:0];
    base    = SUM_W'(word_sh) <<< BASE_SHIFT;
    p1      = SUM_W'(recent) * SUM_W'(c1);
    p2      = SUM_W'(older) * SUM_W'(c2);
    sum     = base + p1 + p2;
    div     = sum >>> 6;
    ovf     = !((&div[SUM_W-1:HIST_W-1]) || (~|div[SUM_W-1:HIST_W-1]));
    if (ovf) begin
      next_hist = div[SUM_W-1] ? HIST_MIN : HIST_MAX;
    end else begin
      next_hist = div[HIST_W-1:0];
    end
  end

  // Sequencer over the nibbles of a job.
  always_comb begin
    state_nxt  = state_r;
    stereo_nxt = stereo_r;
    ch_nxt     = ch_r;
    idx_nxt    = idx_r;
    lrec_nxt   = lrec_r;
    lold_nxt   = lold_r;
    rrec_nxt   = rrec_r;
    rold_nxt   = rold_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt  = ST_RUN;
          stereo_nxt = head_job.stereo;
          ch_nxt     = 1'b0;
          idx_nxt    = '0;
          if (head_job.clear) begin
            lrec_nxt = '0;
            lold_nxt = '0;
            rrec_nxt = '0;
            rold_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          if (ch_r) begin
            rold_nxt = rrec_r;
            rrec_nxt = next_hist;
          end else begin
            lold_nxt = lrec_r;
            lrec_nxt = next_hist;
          end
          if (stereo_r && !ch_r) begin
            ch_nxt = 1'b1;
          end else begin
            ch_nxt  = 1'b0;
            idx_nxt = idx_r + 1'b1;
          end
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stereo_r    <= 1'b0;
      ch_r        <= 1'b0;
      idx_r       <= '0;
      lrec_r      <= '0;
      lold_r      <= '0;
      rrec_r      <= '0;
      rold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stereo_r    <= stereo_nxt;
      ch_r        <= ch_nxt;
      idx_r       <= idx_nxt;
      lrec_r      <= lrec_nxt;
      lold_r      <= lold_nxt;
      rrec_r      <= rrec_nxt;
      rold_r      <= rold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job data shifts one nibble per finished nibble index.
  always_ff @(posedge clk) begin
    if (pop) begin
      l_hdr_r  <= head_job.l_hdr;
      r_hdr_r  <= head_job.r_hdr;
      l_data_r <= head_job.l_data;
      r_data_r <= head_job.r_data;
    end else if (adv && !(stereo_r && !ch_r)) begin
      l_data_r <= l_data_r >> 4;
      r_data_r <= r_data_r >> 4;
    end
  end

  // Output register holds the new history value of the word.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hist_r <= next_hist;
      out_ch_r   <= ch_r;
      out_last_r <= last;
    end
  end

  // History to PCM: truncate toward zero, then clamp to 16 bits.
  always_comb begin
    h_ext = {out_hist_r[HIST_W-1], out_hist_r};
    adj   = h_ext + (out_hist_r[HIST_W-1] ? ROUND_BIAS : '0);
    quo   = adj >>> FRACTION_BITS;
    if (quo > PCM_MAX) begin
      out_sample = 16'sh7FFF;
    end else if (quo < PCM_MIN) begin
      out_sample = -16'sh8000;
    end else begin
      out_sample = quo[15:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_ch_r;
  assign out_last_of_block = out_last_r;

endmodule

// ===== hw/rtl/vag_adpcm_block_decoder_core.sv =====
// ============================================================================
// vag_adpcm_block_decoder_core: VAG ADPCM block decoder top level
// Front intake, two-entry job queue, decoder of one nibble per unstalled cycle.
// ============================================================================
// Each input word is one 16-byte ADPCM block. The front takes a word whenever
// the job queue has room, so up to two decode jobs can wait while samples
// drain. The back decodes one nibble per cycle through a single predictor
// unit while the output side does not stall: it loads a job from the queue,
// then gives 28 samples for a mono block or 56 interleaved samples for a
// stereo pair. Left blocks held for pairing, end flags and blocks after the
// end of stream produce no samples and are never queued for the back.
module vag_adpcm_block_decoder_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  input  logic [7:0]         in_block_header,
  input  logic [7:0]         in_block_flag,
  input  logic [63:0]        in_data_low,
  input  logic [47:0]        in_data_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_channel,
  output logic               out_last_of_block
);
  import vagd_pkg::*;

  vagd_job_t      push_job;
  vagd_job_t      head_job;
  vagd_q_status_t q_status;
  logic           push;
  logic           pop;

  // Intake and classification.
  vagd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .in_block_header (in_block_header),
    .in_block_flag   (in_block_flag),
    .in_data_low     (in_data_low),
    .in_data_high    (in_data_high),
    .q_status        (q_status),
    .push            (push),
    .push_job        (push_job)
  );

  // Job queue between the two sides.
  vagd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Decoder and output register.
  vagd_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .q_status          (q_status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_channel       (out_channel),
    .out_last_of_block (out_last_of_block)
  );

endmodule
